/* sv/hvc_pkg.sv */
// ----------------------------------------------------------------------------
// hvc_pkg
// Constants, register indexes and stream widths for the height and
// velocity controller.
// ----------------------------------------------------------------------------
package hvc_pkg;

  // fraction bits of the raw measurement formats
  localparam int POS_FRAC   = 8;
  localparam int SPEED_FRAC = 19;
  localparam int ACCEL_FRAC = 10;

  // shifts to Q16.16
  localparam int POS_SHL = (POS_FRAC <= 16) ? 16 - POS_FRAC : 0;
  localparam int POS_SHR = (POS_FRAC > 16) ? POS_FRAC - 16 : 0;
  localparam int SPD_SHL = (SPEED_FRAC <= 16) ? 16 - SPEED_FRAC : 0;
  localparam int SPD_SHR = (SPEED_FRAC > 16) ? SPEED_FRAC - 16 : 0;
  localparam int ACC_SHR = (ACCEL_FRAC > 16) ? ACCEL_FRAC - 16 : 0;
  // final shift of the damping product, the up-shift folded in
  localparam int ACC_DSH = (ACCEL_FRAC <= 16) ? ACCEL_FRAC : 16;

  // difference equation coefficients, Q16
  localparam logic [16:0] C_T1 = 17'd108475;
  localparam logic [15:0] C_T2 = 16'd42939;
  localparam logic [23:0] C_E0 = 24'd13700648;
  localparam logic [24:0] C_E1 = 25'd27117873;
  localparam logic [23:0] C_E2 = 24'd13418168;

  // correction: 2 * (E0 - E1 + E2) = 1886 = 3 * 628 + 2
  localparam logic [9:0]  CORR_WHOLE = 10'd628;
  localparam logic [16:0] THIRD_18   = 17'd87381;    // (2^18 - 1) / 3
  localparam logic [18:0] RECIP3     = 19'd349526;   // ceil(2^20 / 3)
  localparam int          RECIP3_SH  = 20;
  localparam logic [24:0] RECIP100   = 25'd21474837; // ceil(2^31 / 100)
  localparam int          RECIP100_SH = 31;
  localparam logic [23:0] DIV_SAT    = 24'h800000;   // far beyond either limit

  localparam logic [15:0] THR_LO = 16'd13107;
  localparam logic [15:0] THR_HI = 16'd52429;
  localparam logic [15:0] THR_DEFAULT_RST = 16'd32768;
  localparam logic [23:0] GAIN_P_RST = 24'd3277;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_SETPOINT = 3'd0,
    REG_HEIGHT_ENABLE   = 3'd1,
    REG_VELOCITY_MODE   = 3'd2,
    REG_THRUST_DEFAULT  = 3'd3,
    REG_TARGET_VEL_X    = 3'd4,
    REG_TARGET_VEL_Y    = 3'd5,
    REG_VEL_GAIN_P      = 3'd6,
    REG_VEL_GAIN_D      = 3'd7
  } cfg_reg_t;

endpackage

/* sv/height_velocity_controller.sv */
// ----------------------------------------------------------------------------
// height_velocity_controller
// Second-order height loop with thrust clamp and a PD velocity loop.
//
// One request on s_axis carries a control tick's measurements; one request
// on m_axis carries the thrust, pitch and roll commands for it.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no request is in flight.
// The datapath is a seven-register pipeline ending in m_axis_tvalid, and one
// request is accepted per cycle while m_axis does not stall.
// The thrust recurrence closes inside one stage, so back-to-back
// requests see each other's history in order.
// Each stage holds its request until the next stage is free; with m_axis
// stalled the pipeline fills up to seven requests, then s_axis_tready drops.
// Reset empties the pipeline, clears the height and thrust history and
// returns every configuration register to its default.
// ----------------------------------------------------------------------------
module height_velocity_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // height_meas, vel_x_meas, vel_y_meas, acc_x_meas, acc_y_meas
  input  logic [hvc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // thrust_cmd, pitch_cmd, roll_cmd
  output logic [hvc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // thrust_limited
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hvc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hvc_pkg::*;

  localparam int HEW = 33 + POS_SHL;
  localparam int VDW = 33 + SPD_SHL;
  localparam int PTW = VDW + 9;
  localparam int DTW = 58 - ACC_DSH;
  localparam int VSW = ((PTW > DTW) ? PTW : DTW) + 1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x[63:31] == '0 || x[63:31] == '1) begin
      return x[31:0];
    end
    return x[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x[63:47] == '0 || x[63:47] == '1) begin
      return x[47:0];
    end
    return x[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
  endfunction

  // base + trunc(x / 100); x saturated first, the limits lie well inside
  function automatic logic signed [18:0] thrust_level(input logic signed [48:0] x,
                                                      input logic [15:0] base);
    logic [48:0]        mag;
    logic [23:0]        mag_sat;
    logic [48:0]        prod;
    logic [16:0]        q;
    logic signed [18:0] qs;
    mag     = x[48] ? 49'(-x) : 49'(x);
    mag_sat = (mag >= 49'(DIV_SAT)) ? DIV_SAT : mag[23:0];
    prod    = 49'(mag_sat) * 49'(RECIP100);
    q       = prod[RECIP100_SH+16:RECIP100_SH];
    qs      = 19'(q);
    if (x[48]) begin
      qs = -qs;
    end
    return $signed({3'b000, base}) + qs;
  endfunction

  // configuration
  logic signed [31:0] height_setpoint;
  logic               height_enable;
  logic               velocity_mode;
  logic [15:0]        thrust_default;
  logic signed [31:0] target_vel_x;
  logic signed [31:0] target_vel_y;
  logic [23:0]        vel_gain_p;
  logic [23:0]        vel_gain_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_setpoint <= '0;
      height_enable   <= 1'b0;
      velocity_mode   <= 1'b0;
      thrust_default  <= THR_DEFAULT_RST;
      target_vel_x    <= '0;
      target_vel_y    <= '0;
      vel_gain_p      <= GAIN_P_RST;
      vel_gain_d      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEIGHT_SETPOINT: height_setpoint <= cfg_data;
        REG_HEIGHT_ENABLE:   height_enable   <= cfg_data[0];
        REG_VELOCITY_MODE:   velocity_mode   <= cfg_data[0];
        REG_THRUST_DEFAULT:  thrust_default  <= cfg_data[15:0];
        REG_TARGET_VEL_X:    target_vel_x    <= cfg_data;
        REG_TARGET_VEL_Y:    target_vel_y    <= cfg_data;
        REG_VEL_GAIN_P:      vel_gain_p      <= cfg_data[23:0];
        REG_VEL_GAIN_D:      vel_gain_d      <= cfg_data[23:0];
      endcase
    end
  end

  // pipeline control
  logic [6:0] stage_valid;
  logic [7:0] rdy;
  logic [6:0] load;

  assign rdy[7]      = m_axis_tready;
  assign rdy[6:0]    = ~stage_valid | rdy[7:1];
  assign load[0]     = s_axis_tvalid & rdy[0];
  assign load[6:1]   = stage_valid[5:0] & rdy[6:1];
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = stage_valid[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= (rdy[6:0] & {stage_valid[5:0], s_axis_tvalid})
                   | (~rdy[6:0] & stage_valid);
    end
  end

  // stage 0: input register
  logic signed [31:0] in_h, in_vx, in_vy, in_ax, in_ay;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      in_h  <= s_axis_tdata[31:0];
      in_vx <= s_axis_tdata[63:32];
      in_vy <= s_axis_tdata[95:64];
      in_ax <= s_axis_tdata[127:96];
      in_ay <= s_axis_tdata[159:128];
    end
  end

  // stage 1: height error, velocity error, negated acceleration
  logic signed [32:0]    herr_diff;
  logic signed [HEW-1:0] herr_q;
  logic signed [VDW-1:0] vq_x, vq_y;
  logic signed [31:0]    s1_e;
  logic signed [VDW-1:0] s1_vdx, s1_vdy;
  logic signed [32:0]    s1_nax, s1_nay;

  always_comb begin
    herr_diff = 33'(height_setpoint) - 33'(in_h);
    herr_q    = (HEW'(herr_diff) <<< POS_SHL) >>> POS_SHR;
    vq_x      = (VDW'(in_vx) <<< SPD_SHL) >>> SPD_SHR;
    vq_y      = (VDW'(in_vy) <<< SPD_SHL) >>> SPD_SHR;
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_e   <= sat32(64'(herr_q));
      s1_vdx <= VDW'(target_vel_x) - vq_x;
      s1_vdy <= VDW'(target_vel_y) - vq_y;
      s1_nax <= -(33'(in_ax) >>> ACC_SHR);
      s1_nay <= -(33'(in_ay) >>> ACC_SHR);
    end
  end

  // stage 2: error and velocity products
  logic signed [31:0]    e_prev;
  logic signed [56:0]    prod_e0, prod_e2;
  logic signed [57:0]    prod_e1;
  logic signed [VDW+24:0] pprod_x, pprod_y;
  logic signed [57:0]    dprod_x, dprod_y;
  logic signed [40:0]    s2_a0, s2_a2;
  logic signed [41:0]    s2_a1;
  logic signed [PTW-1:0] s2_ptx, s2_pty;
  logic signed [DTW-1:0] s2_dtx, s2_dty;
  logic signed [33:0]    s2_s;

  always_comb begin
    prod_e0 = s1_e * $signed({1'b0, C_E0});
    prod_e1 = s1_e * $signed({1'b0, C_E1});
    prod_e2 = s1_e * $signed({1'b0, C_E2});
    pprod_x = s1_vdx * $signed({1'b0, vel_gain_p});
    pprod_y = s1_vdy * $signed({1'b0, vel_gain_p});
    dprod_x = s1_nax * $signed({1'b0, vel_gain_d});
    dprod_y = s1_nay * $signed({1'b0, vel_gain_d});
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_a0  <= prod_e0[56:16];
      s2_a1  <= prod_e1[57:16];
      s2_a2  <= prod_e2[56:16];
      s2_ptx <= pprod_x[VDW+24:16];
      s2_pty <= pprod_y[VDW+24:16];
      s2_dtx <= dprod_x[57:ACC_DSH];
      s2_dty <= dprod_y[57:ACC_DSH];
      s2_s   <= (34'(s1_e) <<< 1) + 34'(e_prev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_prev <= '0;
    end else if (load[2]) begin
      e_prev <= s1_e;
    end
  end

  // stage 3: error part of the difference equation, pitch and roll,
  // correction partial products
  logic signed [41:0] a1_d1;
  logic signed [40:0] a2_d1, a2_d2;
  logic signed [VSW-1:0] vsum_x, vsum_y;
  logic [32:0]        smag;
  logic [33:0]        s_dbl;
  logic [18:0]        x3;
  logic [37:0]        f3_prod;
  logic signed [43:0] s3_p;
  logic signed [31:0] s3_pitch, s3_roll;
  logic               s3_sneg;
  logic [42:0]        s3_m628;
  logic [32:0]        s3_mh;
  logic [17:0]        s3_f3;

  always_comb begin
    vsum_x  = VSW'(s2_ptx) + VSW'(s2_dtx);
    vsum_y  = VSW'(s2_pty) + VSW'(s2_dty);
    smag    = s2_s[33] ? 33'(-s2_s) : 33'(s2_s);
    s_dbl   = {smag, 1'b0};
    // 2^18 is 1 mod 3: fold the high part onto the low part
    x3      = 19'(s_dbl[33:18]) + 19'(s_dbl[17:0]);
    f3_prod = 38'(x3) * 38'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s3_p     <= 44'(s2_a0) - 44'(a1_d1) + 44'(a2_d2);
      s3_pitch <= velocity_mode ? sat32(64'(vsum_x)) : '0;
      s3_roll  <= velocity_mode ? sat32(64'(vsum_y)) : '0;
      s3_sneg  <= s2_s[33];
      s3_m628  <= 43'(smag) * 43'(CORR_WHOLE);
      s3_mh    <= 33'(s_dbl[33:18]) * 33'(THIRD_18);
      s3_f3    <= f3_prod[RECIP3_SH+17:RECIP3_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_d1 <= '0;
      a2_d1 <= '0;
      a2_d2 <= '0;
    end else if (load[3]) begin
      a1_d1 <= s2_a1;
      a2_d2 <= a2_d1;
      a2_d1 <= s2_a2;
    end
  end

  // stage 4: thrust recurrence and correction term
  logic signed [47:0] t_prev;
  logic signed [48:0] mt2_prev;
  logic signed [65:0] mt1;
  logic signed [64:0] mt2;
  logic signed [51:0] t_raw;
  logic signed [47:0] tk;
  logic [44:0]        dsum;
  logic signed [44:0] quot;
  logic signed [47:0] s4_tk;
  logic signed [28:0] s4_corr;
  logic signed [31:0] s4_pitch, s4_roll;

  always_comb begin
    mt1   = t_prev * $signed({1'b0, C_T1});
    mt2   = t_prev * $signed({1'b0, C_T2});
    t_raw = 52'($signed(mt1[65:16])) - 52'(mt2_prev) + 52'(s3_p);
    tk    = height_enable ? sat48(64'(t_raw)) : '0;
    dsum  = 45'(s3_m628) + 45'(s3_mh) + 45'(s3_f3);
    quot  = s3_sneg ? -$signed(dsum) : $signed(dsum);
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s4_tk    <= tk;
      s4_corr  <= quot[44:16];
      s4_pitch <= s3_pitch;
      s4_roll  <= s3_roll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_prev   <= '0;
      mt2_prev <= '0;
    end else if (load[4]) begin
      t_prev   <= tk;
      mt2_prev <= mt2[64:16];
    end
  end

  // stage 5: limit test, corrected term
  logic signed [18:0] lvl0;
  logic signed [48:0] s5_tkc;
  logic signed [18:0] s5_lvl0;
  logic               s5_lim;
  logic signed [31:0] s5_pitch, s5_roll;

  assign lvl0 = thrust_level(49'(s4_tk), thrust_default);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s5_tkc   <= 49'(s4_tk) - 49'(s4_corr);
      s5_lvl0  <= lvl0;
      s5_lim   <= (lvl0 < $signed({3'b000, THR_LO})) || (lvl0 > $signed({3'b000, THR_HI}));
      s5_pitch <= s4_pitch;
      s5_roll  <= s4_roll;
    end
  end

  // stage 6: output register
  logic signed [18:0] lvl1;
  logic signed [18:0] lvl;
  logic [15:0]        o_thrust;
  logic signed [31:0] o_pitch, o_roll;
  logic               o_lim;

  always_comb begin
    lvl1 = thrust_level(s5_tkc, thrust_default);
    lvl  = s5_lim ? lvl1 : s5_lvl0;
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      if (lvl < $signed({3'b000, THR_LO})) begin
        o_thrust <= THR_LO;
      end else if (lvl > $signed({3'b000, THR_HI})) begin
        o_thrust <= THR_HI;
      end else begin
        o_thrust <= lvl[15:0];
      end
      o_pitch <= s5_pitch;
      o_roll  <= s5_roll;
      o_lim   <= s5_lim;
    end
  end

  assign m_axis_tdata = {o_roll, o_pitch, o_thrust};
  assign m_axis_tuser = o_lim;

endmodule
